// ===== hw/rtl/ppst_pkg.sv =====
// ----------------------------------------------------------------------------
// ppst_pkg
// Shared widths, codes and types of the projectile pair speed tracker.
// ----------------------------------------------------------------------------
package ppst_pkg;

	localparam int SLOTS      = 5;
	localparam int SLOT_W     = 3;
	localparam int LEN_W      = 3;
	localparam int CMD_W      = 2;
	localparam int FINE_W     = 16;
	localparam int COARSE_W   = 32;
	localparam int STATUS_W   = 3;
	localparam int SPEED_W    = 16;
	localparam int CNT_W      = 32;
	localparam int EVN_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_REAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FRONT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_TAKEN = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_VALID = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_OOR   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_SPUR  = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_DONE  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

	localparam logic [15:0] RST_MIN_SPEED = 16'd1280;
	localparam logic [15:0] RST_MAX_SPEED = 16'd12800;
	localparam logic [31:0] RST_TIMEOUT   = 32'd100;

	// 1000 m/s per (m per 50 us tick) scaled to Q8.8: 256000 / ticks
	localparam int QUO_W = 18;
	localparam logic [QUO_W-1:0]   SPEED_NUM = 18'd256000;
	localparam logic [SPEED_W-1:0] SPEED_SAT = 16'hFFFF;
	localparam logic [FINE_W-1:0]  SAT_DELTA = 16'd4;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd17;

	typedef logic [SLOTS-1:0][SLOT_W-1:0] order_t;

	typedef struct packed {
		logic              start;
		logic [FINE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [SPEED_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/ppst_evt_if.sv =====
// ----------------------------------------------------------------------------
// ppst_evt_if
// Gate event channel: one word per rear, front or timeout-check event.
// ----------------------------------------------------------------------------
interface ppst_evt_if;
	import ppst_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [FINE_W-1:0]   fine_time;
	logic [COARSE_W-1:0] coarse_time_ms;

	modport source (output valid, command, fine_time, coarse_time_ms, input ready);
	modport sink (input valid, command, fine_time, coarse_time_ms, output ready);
endinterface

// ===== hw/rtl/ppst_res_if.sv =====
// ----------------------------------------------------------------------------
// ppst_res_if
// Result channel: one word per processed event.
// ----------------------------------------------------------------------------
interface ppst_res_if;
	import ppst_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOTS-1:0]    slot_mask;
	logic [SLOT_W-1:0]   slot_index;
	logic [FINE_W-1:0]   delta_ticks;
	logic                wrapped;
	logic [SPEED_W-1:0]  speed_q8;
	logic [CNT_W-1:0]    shot_total;
	logic [EVN_W-1:0]    evicted_now;
	logic [CNT_W-1:0]    evicted_total;
	logic [CNT_W-1:0]    front_events;
	logic [CNT_W-1:0]    rear_events;

	modport source (output valid, status, slot_mask, slot_index, delta_ticks, wrapped,
		speed_q8, shot_total, evicted_now, evicted_total, front_events, rear_events,
		input ready);
	modport sink (input valid, status, slot_mask, slot_index, delta_ticks, wrapped,
		speed_q8, shot_total, evicted_now, evicted_total, front_events, rear_events,
		output ready);
endinterface

// ===== hw/rtl/ppst_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ppst_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ppst_cfg_if;
	import ppst_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, reg_index, data, input ready);
	modport sink (input valid, reg_index, data, output ready);
endinterface

// ===== hw/rtl/projectile_pair_speed_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// projectile_pair_speed_tracker_unit
// Pairs rear and front gate events into shots and reports Q8.8 speed.
// ----------------------------------------------------------------------------
// Events are taken one at a time. A rear event, an unused command, a front
// event on an empty barrel or one with a zero tick delta goes straight from
// acceptance to the finish state; a front event with a tick delta of 1 to 3
// passes through the speed compare first, a timeout check through the age
// compare one slot per cycle, and a front event with a tick delta of 4 or
// more through the 18-step restoring divider and then the compare. The result
// sits in an output register, so the next event is taken while the last word
// waits for ready. Drains follow allocation order, not slot index.
module projectile_pair_speed_tracker_unit (
	input logic  clk,
	input logic  arst_n,
	ppst_cfg_if.sink   cfg,
	ppst_evt_if.sink   evt,
	ppst_res_if.source res
);
	import ppst_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [15:0]         min_q;
	logic [15:0]         max_q;
	logic [31:0]         timeout_q;
	logic [SLOTS-1:0]    mask_q;
	logic [LEN_W-1:0]    len_q;
	logic [SLOT_W-1:0]   scan_q;
	logic [CNT_W-1:0]    shot_q;
	logic [CNT_W-1:0]    evict_tot_q;
	logic [CNT_W-1:0]    front_q;
	logic [CNT_W-1:0]    rear_q;
	logic                res_valid_q;

	logic [FINE_W-1:0]   fine_stamp_q [SLOTS];
	logic [COARSE_W-1:0] coarse_stamp_q [SLOTS];
	order_t              order_q;
	logic [COARSE_W-1:0] coarse_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   index_q;
	logic [FINE_W-1:0]   delta_q;
	logic                wrapped_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [EVN_W-1:0]    evicted_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [SLOTS-1:0]    res_mask_q;
	logic [SLOT_W-1:0]   res_index_q;
	logic [FINE_W-1:0]   res_delta_q;
	logic                res_wrapped_q;
	logic [SPEED_W-1:0]  res_speed_q;
	logic [CNT_W-1:0]    res_shot_q;
	logic [EVN_W-1:0]    res_evicted_q;
	logic [CNT_W-1:0]    res_evict_tot_q;
	logic [CNT_W-1:0]    res_front_q;
	logic [CNT_W-1:0]    res_rear_q;

	logic                accept;
	logic                free_found;
	logic [SLOT_W-1:0]   free_idx;
	logic [SLOT_W-1:0]   front_slot;
	logic [FINE_W-1:0]   front_stamp;
	logic [FINE_W-1:0]   front_delta;
	order_t              order_drop_front;
	order_t              order_drop_scan;
	logic [COARSE_W-1:0] scan_age;
	logic                scan_hit;
	logic                speed_ok;
	logic                out_free;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// remove one slot from the allocation list, closing the gap
	function automatic order_t drop_slot(order_t ord, logic [SLOT_W-1:0] slot,
		logic [LEN_W-1:0] len);
		order_t nxt;
		logic   hit;
		nxt = ord;
		hit = 1'b0;
		for (int p = 0; p < SLOTS; p++) begin
			if (LEN_W'(p) < len && ord[p] == slot) begin
				hit = 1'b1;
			end
			if (hit && p < SLOTS - 1) begin
				nxt[p] = ord[p+1];
			end
		end
		return nxt;
	endfunction

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!mask_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign accept           = evt.valid && evt.ready;
	assign front_slot       = order_q[0];
	assign front_stamp      = fine_stamp_q[front_slot];
	assign front_delta      = evt.fine_time - front_stamp;
	assign order_drop_front = drop_slot(order_q, front_slot, len_q);
	assign order_drop_scan  = drop_slot(order_q, scan_q, len_q);
	assign scan_age         = coarse_q - coarse_stamp_q[scan_q];
	assign scan_hit         = mask_q[scan_q] && (scan_age >= timeout_q);
	assign speed_ok         = (speed_q >= min_q) && (speed_q <= max_q);
	assign out_free         = !res_valid_q || res.ready;

	assign div_req.start   = accept && (evt.command == CMD_FRONT) && (len_q != '0)
		&& (front_delta >= SAT_DELTA);
	assign div_req.divisor = front_delta;

	ppst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_q       <= RST_MIN_SPEED;
			max_q       <= RST_MAX_SPEED;
			timeout_q   <= RST_TIMEOUT;
			mask_q      <= '0;
			len_q       <= '0;
			scan_q      <= '0;
			shot_q      <= '0;
			evict_tot_q <= '0;
			front_q     <= '0;
			rear_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.reg_index)
					REG_MIN_SPEED: min_q     <= cfg.data[15:0];
					REG_MAX_SPEED: max_q     <= cfg.data[15:0];
					REG_TIMEOUT:   timeout_q <= cfg.data;
					default: ;
				endcase
			end
			if (state_q == S_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (evt.command)
							CMD_REAR: begin
								rear_q  <= rear_q + 1'b1;
								state_q <= S_FIN;
								if (free_found) begin
									mask_q[free_idx] <= 1'b1;
									len_q            <= len_q + 1'b1;
								end
							end
							CMD_FRONT: begin
								front_q <= front_q + 1'b1;
								if (len_q == '0) begin
									state_q <= S_FIN;
								end else begin
									mask_q[front_slot] <= 1'b0;
									len_q              <= len_q - 1'b1;
									if (div_req.start) begin
										state_q <= S_DIV;
									end else if (front_delta != '0) begin
										state_q <= S_CMP;
									end else begin
										state_q <= S_FIN;
									end
								end
							end
							CMD_CHECK: begin
								scan_q  <= '0;
								state_q <= S_SCAN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (speed_ok) begin
						shot_q <= shot_q + 1'b1;
					end
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (scan_hit) begin
						mask_q[scan_q] <= 1'b0;
						len_q          <= len_q - 1'b1;
						evict_tot_q    <= evict_tot_q + 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					coarse_q  <= evt.coarse_time_ms;
					evicted_q <= '0;
					case (evt.command)
						CMD_REAR: begin
							delta_q   <= '0;
							wrapped_q <= 1'b0;
							speed_q   <= '0;
							if (free_found) begin
								fine_stamp_q[free_idx]   <= evt.fine_time;
								coarse_stamp_q[free_idx] <= evt.coarse_time_ms;
								order_q[len_q]           <= free_idx;
								status_q                 <= STAT_TAKEN;
								index_q                  <= free_idx;
							end else begin
								status_q <= STAT_FULL;
								index_q  <= '0;
							end
						end
						CMD_FRONT: begin
							if (len_q == '0) begin
								status_q  <= STAT_SPUR;
								index_q   <= '0;
								delta_q   <= '0;
								wrapped_q <= 1'b0;
								speed_q   <= '0;
							end else begin
								status_q  <= STAT_OOR;
								index_q   <= front_slot;
								delta_q   <= front_delta;
								wrapped_q <= evt.fine_time < front_stamp;
								order_q   <= order_drop_front;
								if (front_delta != '0 && !div_req.start) begin
									speed_q <= SPEED_SAT;
								end else begin
									speed_q <= '0;
								end
							end
						end
						default: begin
							status_q  <= STAT_DONE;
							index_q   <= '0;
							delta_q   <= '0;
							wrapped_q <= 1'b0;
							speed_q   <= '0;
						end
					endcase
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					speed_q <= div_rsp.quotient;
				end
			end
			S_CMP: begin
				status_q <= speed_ok ? STAT_VALID : STAT_OOR;
			end
			S_SCAN: begin
				if (scan_hit) begin
					order_q   <= order_drop_scan;
					evicted_q <= evicted_q + 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					res_status_q    <= status_q;
					res_mask_q      <= mask_q;
					res_index_q     <= index_q;
					res_delta_q     <= delta_q;
					res_wrapped_q   <= wrapped_q;
					res_speed_q     <= speed_q;
					res_shot_q      <= shot_q;
					res_evicted_q   <= evicted_q;
					res_evict_tot_q <= evict_tot_q;
					res_front_q     <= front_q;
					res_rear_q      <= rear_q;
				end
			end
			default: ;
		endcase
	end

	assign cfg.ready         = 1'b1;
	assign evt.ready         = (state_q == S_IDLE);
	assign res.valid         = res_valid_q;
	assign res.status        = res_status_q;
	assign res.slot_mask     = res_mask_q;
	assign res.slot_index    = res_index_q;
	assign res.delta_ticks   = res_delta_q;
	assign res.wrapped       = res_wrapped_q;
	assign res.speed_q8      = res_speed_q;
	assign res.shot_total    = res_shot_q;
	assign res.evicted_now   = res_evicted_q;
	assign res.evicted_total = res_evict_tot_q;
	assign res.front_events  = res_front_q;
	assign res.rear_events   = res_rear_q;

	a_len_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		len_q == LEN_W'($countones(mask_q)))
		else $error("allocation list length differs from occupied slot count");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted word did not start processing");

	a_fin_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> res_valid_q)
		else $error("finished word not presented");

endmodule

// ===== hw/rtl/ppst_div.sv =====
// ----------------------------------------------------------------------------
// ppst_div
// Restoring divider, one quotient bit per cycle: 256000 / divisor.
// ----------------------------------------------------------------------------
module ppst_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ppst_pkg::div_req_t req,
	output ppst_pkg::div_rsp_t rsp
);
	import ppst_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FINE_W-1:0]    rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [FINE_W-1:0]    dvs_q;
	logic [FINE_W:0]      shifted;
	logic [FINE_W:0]      diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[QUO_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= SPEED_NUM;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FINE_W-1:0] : shifted[FINE_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[SPEED_W-1:0];

endmodule

// ===== verif/projectile_pair_speed_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// projectile_pair_speed_tracker_unit_tb
// Drives rear, front and timeout-check events into the tracker under several
// speed-bound and timeout settings, predicts every result word in a barrel
// model of its own, and checks each returned word field by field.
// ----------------------------------------------------------------------------
module projectile_pair_speed_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppst_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOTS-1:0]    slot_mask;
		logic [SLOT_W-1:0]   slot_index;
		logic [FINE_W-1:0]   delta_ticks;
		logic                wrapped;
		logic [SPEED_W-1:0]  speed_q8;
		logic [CNT_W-1:0]    shot_total;
		logic [EVN_W-1:0]    evicted_now;
		logic [CNT_W-1:0]    evicted_total;
		logic [CNT_W-1:0]    front_events;
		logic [CNT_W-1:0]    rear_events;
	} report_t;

	class barrel_tracker;
		logic [15:0]         min_speed;
		logic [15:0]         max_speed;
		logic [31:0]         age_limit;
		logic [SLOTS-1:0]    occupied;
		logic [FINE_W-1:0]   fine_stamp[SLOTS];
		logic [COARSE_W-1:0] coarse_stamp[SLOTS];
		int unsigned         alloc_order[$];
		logic [CNT_W-1:0]    shots, evictions, fronts, rears;
		report_t             reports_due[$];
		int                  errors;

		function new();
			min_speed  = RST_MIN_SPEED;
			max_speed  = RST_MAX_SPEED;
			age_limit  = RST_TIMEOUT;
			occupied   = '0;
			shots      = '0;
			evictions  = '0;
			fronts     = '0;
			rears      = '0;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MIN_SPEED: min_speed = data[15:0];
				REG_MAX_SPEED: max_speed = data[15:0];
				REG_TIMEOUT: age_limit = data;
				default: ;
			endcase
		endfunction

		function void drop_slot(int unsigned s);
			int k;
			for (k = alloc_order.size() - 1; k >= 0; k--)
				if (alloc_order[k] == s)
					alloc_order.delete(k);
		endfunction

		function void log_gate_event(logic [CMD_W-1:0] cmd, logic [FINE_W-1:0] fine,
			logic [COARSE_W-1:0] coarse);
			report_t       w;
			int unsigned   i, s, q;
			logic [15:0]   d;
			logic [31:0]   age;
			w = '0;
			w.status = STAT_DONE;
			case (cmd)
				CMD_REAR: begin
					rears++;
					w.status = STAT_FULL;
					for (i = 0; i < SLOTS; i++) begin
						if (!occupied[i]) begin
							occupied[i] = 1'b1;
							fine_stamp[i] = fine;
							coarse_stamp[i] = coarse;
							alloc_order.push_back(i);
							w.status = STAT_TAKEN;
							w.slot_index = i[SLOT_W-1:0];
							break;
						end
					end
				end
				CMD_FRONT: begin
					fronts++;
					if (alloc_order.size() == 0) begin
						w.status = STAT_SPUR;
					end else begin
						s = alloc_order.pop_front();
						w.slot_index = s[SLOT_W-1:0];
						w.wrapped = fine < fine_stamp[s];
						d = fine - fine_stamp[s];
						w.delta_ticks = d;
						q = 0;
						if (d != 0) begin
							q = 32'd256000 / 32'(d);
							if (q > 65535)
								q = 65535;
						end
						w.speed_q8 = q[15:0];
						if (d != 0 && q >= min_speed && q <= max_speed) begin
							shots++;
							w.status = STAT_VALID;
						end else begin
							w.status = STAT_OOR;
						end
						occupied[s] = 1'b0;
					end
				end
				CMD_CHECK: begin
					for (i = 0; i < SLOTS; i++) begin
						age = coarse - coarse_stamp[i];
						if (occupied[i] && age >= age_limit) begin
							occupied[i] = 1'b0;
							drop_slot(i);
							evictions++;
							w.evicted_now++;
						end
					end
				end
				default: ;
			endcase
			w.slot_mask     = occupied;
			w.shot_total    = shots;
			w.evicted_total = evictions;
			w.front_events  = fronts;
			w.rear_events   = rears;
			reports_due.push_back(w);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, seen);
				errors++;
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected result word, expected none actual status %0d",
					$realtime, got.status);
				errors++;
				return;
			end
			want = reports_due.pop_front();
			cmp_field("status", want.status, got.status);
			cmp_field("slot_mask", want.slot_mask, got.slot_mask);
			cmp_field("slot_index", want.slot_index, got.slot_index);
			cmp_field("delta_ticks", want.delta_ticks, got.delta_ticks);
			cmp_field("wrapped", want.wrapped, got.wrapped);
			cmp_field("speed_q8", want.speed_q8, got.speed_q8);
			cmp_field("shot_total", want.shot_total, got.shot_total);
			cmp_field("evicted_now", want.evicted_now, got.evicted_now);
			cmp_field("evicted_total", want.evicted_total, got.evicted_total);
			cmp_field("front_events", want.front_events, got.front_events);
			cmp_field("rear_events", want.rear_events, got.rear_events);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ppst_cfg_if cfg();
	ppst_evt_if evt();
	ppst_res_if res();

	projectile_pair_speed_tracker_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.evt    (evt.sink),
		.res    (res.source)
	);

	barrel_tracker       tracker = new();
	bit                  idle_on = 1'b1;
	bit                  hold_req = 1'b0;
	int                  events_sent = 0;
	logic [FINE_W-1:0]   now_fine;
	logic [COARSE_W-1:0] now_ms;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#6ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		res.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		report_t got;
		if (arst_n && res.valid && res.ready) begin
			got.status        = res.status;
			got.slot_mask     = res.slot_mask;
			got.slot_index    = res.slot_index;
			got.delta_ticks   = res.delta_ticks;
			got.wrapped       = res.wrapped;
			got.speed_q8      = res.speed_q8;
			got.shot_total    = res.shot_total;
			got.evicted_now   = res.evicted_now;
			got.evicted_total = res.evicted_total;
			got.front_events  = res.front_events;
			got.rear_events   = res.rear_events;
			tracker.check_report(got);
		end
	end

	task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [FINE_W-1:0] fine,
		input logic [COARSE_W-1:0] coarse);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			evt.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		evt.valid          <= 1'b1;
		evt.command        <= cmd;
		evt.fine_time      <= fine;
		evt.coarse_time_ms <= coarse;
		do @(posedge clk); while (!evt.ready);
		tracker.log_gate_event(cmd, fine, coarse);
		events_sent++;
	endtask

	task automatic wait_idle();
		evt.valid <= 1'b0;
		while (tracker.reports_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
		input logic [31:0] tmo);
		logic [CFG_IDX_W-1:0]  idxs[3];
		logic [CFG_DATA_W-1:0] vals[3];
		int                    i;
		idxs[0] = REG_MIN_SPEED;
		idxs[1] = REG_MAX_SPEED;
		idxs[2] = REG_TIMEOUT;
		vals[0] = {16'($urandom), lo};
		vals[1] = {16'($urandom), hi};
		vals[2] = tmo;
		wait_idle();
		for (i = 0; i < 3; i++) begin
			cfg.valid     <= 1'b1;
			cfg.reg_index <= idxs[i];
			cfg.data      <= vals[i];
			do @(posedge clk); while (!cfg.ready);
			tracker.write_reg(idxs[i], vals[i]);
		end
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [FINE_W-1:0] pick_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'($urandom_range(20, 200));
		else if (r < 60)
			return 16'($urandom_range(0, 3));
		else if (r < 70)
			return 16'($urandom_range(4, 19));
		else if (r < 82)
			return 16'($urandom_range(201, 2000));
		return 16'($urandom);
	endfunction

	task automatic run_random(input int n);
		logic [FINE_W-1:0] stamps[$];
		int                stop_at, k, j, r;
		stop_at = events_sent + n;
		while (events_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				k = $urandom_range(1, SLOTS + 1);
				stamps.delete();
				for (j = 0; j < k; j++) begin
					now_fine += 16'($urandom_range(0, 400));
					now_ms += $urandom_range(0, 20);
					stamps.push_back(now_fine);
					send_event(CMD_REAR, now_fine, now_ms);
				end
				for (j = 0; j < k; j++)
					if ($urandom_range(0, 9) != 0)
						send_event(CMD_FRONT, stamps[j] + pick_delta(), now_ms);
			end else if (r < 72) begin
				send_event(CMD_CHECK, now_fine, now_ms + $urandom_range(0, 300));
			end else if (r < 80) begin
				now_ms += $urandom_range(0, 400);
			end else begin
				send_event(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg.valid         <= 1'b0;
		cfg.reg_index     <= '0;
		cfg.data          <= '0;
		evt.valid         <= 1'b0;
		evt.command       <= CMD_REAR;
		evt.fine_time     <= '0;
		evt.coarse_time_ms <= '0;
		now_fine = 16'($urandom);
		now_ms   = 32'($urandom_range(0, 100000));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bounds: empty barrel, fill and overflow, drain order, boundaries
		send_event(CMD_FRONT, 16'd0, 32'd0);
		send_event(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		send_event(CMD_CHECK, 16'd0, 32'd0);
		send_event(CMD_REAR, 16'd100, 32'd0);
		send_event(CMD_REAR, 16'hFFFF, 32'd1);
		send_event(CMD_REAR, 16'd0, 32'd2);
		send_event(CMD_REAR, 16'h8000, 32'd3);
		send_event(CMD_REAR, 16'd50, 32'd200);
		send_event(CMD_REAR, 16'hFFFF, 32'hFFFF_FFFF);
		send_event(CMD_FRONT, 16'd100, 32'd205);
		send_event(CMD_REAR, 16'd10, 32'd210);
		send_event(CMD_FRONT, 16'd2, 32'd211);
		send_event(CMD_FRONT, 16'd100, 32'd212);
		send_event(CMD_FRONT, 16'h7FFF, 32'd213);
		send_event(CMD_CHECK, 16'd0, 32'd250);
		send_event(CMD_CHECK, 16'd0, 32'd310);
		send_event(CMD_FRONT, 16'd5, 32'd311);
		send_event(CMD_REAR, 16'd0, 32'hFFFF_FFF0);
		send_event(CMD_CHECK, 16'd0, 32'h0000_0050);
		send_event(CMD_CHECK, 16'd0, 32'h0000_0054);
		send_event(CMD_REAR, 16'd1000, 32'd0);
		send_event(CMD_FRONT, 16'd1020, 32'd0);
		send_event(CMD_REAR, 16'd0, 32'd0);
		send_event(CMD_FRONT, 16'd200, 32'd0);
		send_event(CMD_REAR, 16'd0, 32'd0);
		send_event(CMD_FRONT, 16'd201, 32'd0);

		set_config(16'd0, 16'hFFFF, 32'd0);
		run_random(400);

		set_config(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
		run_random(250);

		set_config(RST_MIN_SPEED, RST_MAX_SPEED, RST_TIMEOUT);
		hold_req = 1'b1;
		run_random(350);

		set_config(16'($urandom_range(0, 8000)), 16'($urandom_range(8000, 65535)),
			$urandom_range(0, 500));
		run_random(450);

		set_config(16'd2000, 16'd20000, 32'd50);
		now_ms = 32'hFFFF_FF00;
		idle_on = 1'b0;
		run_random(450);

		wait_idle();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.reports_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
